### hw/rtl/cq_pkg.sv
// ----------------------------------------------------------------------------
// cq_pkg: shared types and constants for the coordinate quickselect engine
// Record layout, request decode and the memory port bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package cq_pkg;

   localparam int unsigned INDEX_W = 10;
   localparam int unsigned COORD_W = 32;
   localparam int unsigned TAG_W   = 10;
   localparam int unsigned DIM_W   = 2;
   localparam int unsigned TYPE_W  = 2;

   // Axis codes for the select key.
   localparam logic [DIM_W-1:0] DIM_X = 2'd0;
   localparam logic [DIM_W-1:0] DIM_Y = 2'd1;
   localparam logic [DIM_W-1:0] DIM_Z = 2'd2;

   typedef logic [INDEX_W-1:0] pos_type;

   // One point record; whole records move together.
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [TAG_W-1:0]          tag;
   } rec_type;

   typedef enum logic [TYPE_W-1:0] {
      OP_WRITE  = 2'd0,
      OP_SELECT = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Decoded request item.
   typedef struct packed {
      op_type           op;
      logic             refuse;
      pos_type          pos;
      logic [DIM_W-1:0] dim;
      pos_type          lo;
      pos_type          hi;
      pos_type          rank;
      rec_type          rec;
   } cmd_type;

   // One read and one write access per cycle on the record memory.
   typedef struct packed {
      logic    rd_en;
      pos_type rd_pos;
      logic    wr_en;
      pos_type wr_pos;
      rec_type wr_data;
   } mem_req_type;

   // Coordinate of a record on the selected axis.
   function automatic logic signed [COORD_W-1:0] key_of(rec_type rec,
                                                        logic [DIM_W-1:0] dim);
      logic signed [COORD_W-1:0] k;
      case (dim)
         DIM_X:   k = rec.x;
         DIM_Y:   k = rec.y;
         DIM_Z:   k = rec.z;
         default: k = rec.x;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/cq_record_mem.sv
// ----------------------------------------------------------------------------
// cq_record_mem: record memory
// Synchronous single-read, single-write store of point records with a
// registered read and write-to-read forwarding on the same position.
// ----------------------------------------------------------------------------
`default_nettype none

module cq_record_mem #(
   parameter int unsigned DEPTH = 1024
) (
   input  wire                  clock,
   input  cq_pkg::mem_req_type  mem_req,
   output cq_pkg::rec_type      rd_data
);
   import cq_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   rec_type rec_mem [DEPTH];
   rec_type rd_data_ff;

   // Write port and registered read port; a read of the position being
   // written returns the new record.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         rec_mem[AW'(mem_req.wr_pos)] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         if (mem_req.wr_en && (mem_req.wr_pos == mem_req.rd_pos)) begin
            rd_data_ff <= mem_req.wr_data;
         end else begin
            rd_data_ff <= rec_mem[AW'(mem_req.rd_pos)];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/cq_select_ctrl.sv
// ----------------------------------------------------------------------------
// cq_select_ctrl: request sequencer
// Runs writes, reads and the Hoare-partition quickselect over the record
// memory, one access of each kind per cycle, and registers the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module cq_select_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  cq_pkg::cmd_type      cmd,
   output logic                 busy,
   output cq_pkg::mem_req_type  mem_req,
   input  cq_pkg::rec_type      rd_data,
   output logic                 rsp_valid,
   output cq_pkg::rec_type      rsp_rec,
   output logic                 rsp_status
);
   import cq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROUND,
      S_PIVOT,
      S_PIVOT_SWAP,
      S_PIVOT_WB,
      S_ISCAN,
      S_JSCAN,
      S_SWAP_J,
      S_FIN_I,
      S_FIN_R,
      S_RESULT
   } state_type;

   state_type        state_ff, state_in;
   pos_type          l_ff, l_in;
   pos_type          r_ff, r_in;
   pos_type          k_ff, k_in;
   pos_type          i_ff, i_in;
   pos_type          j_ff, j_in;
   logic [DIM_W-1:0] dim_ff, dim_in;
   rec_type          piv_ff, piv_in;
   rec_type          reci_ff, reci_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rec_type          rsp_rec_ff, rsp_rec_in;
   logic             rsp_status_ff, rsp_status_in;

   logic signed [COORD_W-1:0] pivot_key;
   logic signed [COORD_W-1:0] rd_key;

   assign pivot_key = key_of(piv_ff, dim_ff);
   assign rd_key    = key_of(rd_data, dim_ff);

   // Next-state logic and memory accesses.
   always_comb begin
      state_in      = state_ff;
      l_in          = l_ff;
      r_in          = r_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      dim_in        = dim_ff;
      piv_in        = piv_ff;
      reci_in       = reci_ff;
      rsp_valid_in  = 1'b0;
      rsp_rec_in    = rsp_rec_ff;
      rsp_status_in = rsp_status_ff;
      mem_req       = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (cmd.refuse) begin
                  rsp_valid_in  = 1'b1;
                  rsp_rec_in    = '0;
                  rsp_status_in = 1'b1;
               end else begin
                  case (cmd.op)
                     OP_WRITE: begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_pos  = cmd.pos;
                        mem_req.wr_data = cmd.rec;
                        rsp_valid_in    = 1'b1;
                        rsp_rec_in      = cmd.rec;
                        rsp_status_in   = 1'b0;
                     end
                     OP_READ: begin
                        mem_req.rd_en  = 1'b1;
                        mem_req.rd_pos = cmd.pos;
                        state_in       = S_RESULT;
                     end
                     OP_SELECT: begin
                        l_in     = cmd.lo;
                        r_in     = cmd.hi;
                        k_in     = cmd.rank;
                        dim_in   = cmd.dim;
                        state_in = S_ROUND;
                     end
                     default: begin
                        rsp_valid_in  = 1'b1;
                        rsp_rec_in    = '0;
                        rsp_status_in = 1'b1;
                     end
                  endcase
               end
            end
         end

         // Start a partition round, or fetch the record at the rank when done.
         S_ROUND: begin
            mem_req.rd_en  = 1'b1;
            mem_req.rd_pos = k_ff;
            if (r_ff > l_ff) begin
               state_in = S_PIVOT;
            end else begin
               state_in = S_RESULT;
            end
         end

         // Pivot record arrives; fetch the record at the range end.
         S_PIVOT: begin
            piv_in         = rd_data;
            mem_req.rd_en  = 1'b1;
            mem_req.rd_pos = r_ff;
            state_in       = S_PIVOT_SWAP;
         end

         S_PIVOT_SWAP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_pos  = k_ff;
            mem_req.wr_data = rd_data;
            state_in        = S_PIVOT_WB;
         end

         // Pivot goes to the range end; the left scan begins at the low end.
         S_PIVOT_WB: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_pos  = r_ff;
            mem_req.wr_data = piv_ff;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_pos  = l_ff;
            i_in            = l_ff;
            j_in            = r_ff;
            state_in        = S_ISCAN;
         end

         // Left scan: stop at a key not below the pivot or on meeting j.
         S_ISCAN: begin
            reci_in = rd_data;
            if ((rd_key >= pivot_key) || (i_ff == j_ff)) begin
               if (i_ff != j_ff) begin
                  mem_req.rd_en  = 1'b1;
                  mem_req.rd_pos = j_ff - 1'b1;
                  j_in           = j_ff - 1'b1;
                  state_in       = S_JSCAN;
               end else begin
                  state_in = S_FIN_I;
               end
            end else begin
               mem_req.rd_en  = 1'b1;
               mem_req.rd_pos = i_ff + 1'b1;
               i_in           = i_ff + 1'b1;
            end
         end

         // Right scan: stop at a key not above the pivot or on meeting i.
         S_JSCAN: begin
            if ((rd_key <= pivot_key) || (j_ff == i_ff)) begin
               if (j_ff != i_ff) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_pos  = i_ff;
                  mem_req.wr_data = rd_data;
                  state_in        = S_SWAP_J;
               end else begin
                  state_in = S_FIN_I;
               end
            end else begin
               mem_req.rd_en  = 1'b1;
               mem_req.rd_pos = j_ff - 1'b1;
               j_in           = j_ff - 1'b1;
            end
         end

         // Second half of the swap; the left scan resumes at once.
         S_SWAP_J: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_pos  = j_ff;
            mem_req.wr_data = reci_ff;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_pos  = i_ff + 1'b1;
            i_in            = i_ff + 1'b1;
            state_in        = S_ISCAN;
         end

         // Pivot to the meeting point.
         S_FIN_I: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_pos  = i_ff;
            mem_req.wr_data = piv_ff;
            state_in        = S_FIN_R;
         end

         // Displaced record to the range end; keep the side holding the rank.
         S_FIN_R: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_pos  = r_ff;
            mem_req.wr_data = reci_ff;
            if (i_ff == k_ff) begin
               mem_req.rd_en  = 1'b1;
               mem_req.rd_pos = k_ff;
               state_in       = S_RESULT;
            end else if (i_ff > k_ff) begin
               r_in     = i_ff - 1'b1;
               state_in = S_ROUND;
            end else begin
               l_in     = i_ff + 1'b1;
               state_in = S_ROUND;
            end
         end

         S_RESULT: begin
            rsp_valid_in  = 1'b1;
            rsp_rec_in    = rd_data;
            rsp_status_in = 1'b0;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      l_ff          <= l_in;
      r_ff          <= r_in;
      k_ff          <= k_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      dim_ff        <= dim_in;
      piv_ff        <= piv_in;
      reci_ff       <= reci_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_rec    = rsp_rec_ff;
   assign rsp_status = rsp_status_ff;

   // The scan pointers never cross, and stay inside the range.
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_ISCAN) || (state_ff == S_JSCAN)) |-> (i_ff <= j_ff))
      else $error("scan pointers crossed");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_ISCAN) || (state_ff == S_JSCAN)) |->
      ((j_ff <= r_ff) && (i_ff >= l_ff)))
      else $error("scan pointer left the range");

   // Leaving a busy phase always delivers its result item.
   a_done_resp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy phase ended without a result item");

   // A result item comes only from an accepted item or a finished fetch.
   a_resp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past((start && (state_ff == S_IDLE)) || (state_ff == S_RESULT)))
      else $error("result item without a cause");

   // The rank stays inside the active range whenever a pivot record arrives.
   a_round_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PIVOT) |-> ((k_ff >= l_ff) && (k_ff <= r_ff)))
      else $error("rank left the active range");

endmodule

`default_nettype wire

### hw/rtl/coordinate_quickselect.sv
// A write or a refused item gives its result item in the cycle after acceptance;
// a read goes through the registered memory read and then the result register;
// a select runs partition rounds paced by the record memory, with its one read
// and one write port, that every scan step and every record move goes through.
// Writes and refused items may be accepted every cycle; reads and selects hold
// busy until their result. Reset clears control state only, not the records.
// The receiver cannot stall: each result item is shown for one cycle.
// ----------------------------------------------------------------------------
// coordinate_quickselect: selection engine over stored 3-D point records
// Decodes and checks request items and connects the sequencer to the record
// memory.
// ----------------------------------------------------------------------------
`default_nettype none

module coordinate_quickselect #(
   parameter int unsigned DEPTH = 1024
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      start,
   output logic                                     busy,
   input  wire  [cq_pkg::TYPE_W-1:0]                req_type,
   input  wire  [cq_pkg::INDEX_W-1:0]               req_index,
   input  wire  signed [cq_pkg::COORD_W-1:0]        req_coord_x,
   input  wire  signed [cq_pkg::COORD_W-1:0]        req_coord_y,
   input  wire  signed [cq_pkg::COORD_W-1:0]        req_coord_z,
   input  wire  [cq_pkg::TAG_W-1:0]                 req_tag,
   input  wire  [cq_pkg::DIM_W-1:0]                 req_select_dim,
   input  wire  [cq_pkg::INDEX_W-1:0]               req_range_low,
   input  wire  [cq_pkg::INDEX_W-1:0]               req_range_high,
   input  wire  [cq_pkg::INDEX_W-1:0]               req_select_rank,
   output logic                                     rsp_valid,
   output logic signed [cq_pkg::COORD_W-1:0]        rsp_out_x,
   output logic signed [cq_pkg::COORD_W-1:0]        rsp_out_y,
   output logic signed [cq_pkg::COORD_W-1:0]        rsp_out_z,
   output logic [cq_pkg::TAG_W-1:0]                 rsp_out_tag,
   output logic                                     rsp_status
);
   import cq_pkg::*;

   cmd_type     cmd;
   mem_req_type mem_req;
   rec_type     rd_data;
   rec_type     rsp_rec;

   // Request decode and range checks.
   always_comb begin
      cmd.op      = op_type'(req_type);
      cmd.pos     = req_index;
      cmd.dim     = req_select_dim;
      cmd.lo      = req_range_low;
      cmd.hi      = req_range_high;
      cmd.rank    = req_select_rank;
      cmd.rec.x   = req_coord_x;
      cmd.rec.y   = req_coord_y;
      cmd.rec.z   = req_coord_z;
      cmd.rec.tag = req_tag;
      case (cmd.op)
         OP_WRITE, OP_READ: begin
            cmd.refuse = (32'(req_index) >= DEPTH);
         end
         OP_SELECT: begin
            cmd.refuse = !((req_select_dim == DIM_X) || (req_select_dim == DIM_Y) ||
                           (req_select_dim == DIM_Z)) ||
                         (req_select_rank < req_range_low) ||
                         (req_select_rank > req_range_high) ||
                         (32'(req_range_high) >= DEPTH);
         end
         default: begin
            cmd.refuse = 1'b1;
         end
      endcase
   end

   cq_select_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cmd        (cmd),
      .busy       (busy),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .rsp_valid  (rsp_valid),
      .rsp_rec    (rsp_rec),
      .rsp_status (rsp_status)
   );

   cq_record_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign rsp_out_x   = rsp_rec.x;
   assign rsp_out_y   = rsp_rec.y;
   assign rsp_out_z   = rsp_rec.z;
   assign rsp_out_tag = rsp_rec.tag;

endmodule

`default_nettype wire

### tb/quickselect_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quickselect_checker: result checker for the coordinate quickselect engine
// Watches the request and result channels, keeps a mirror of the record
// store, replays each accepted item on it and compares every result item
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------

module quickselect_checker #(
   parameter int unsigned DEPTH = 1024
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire                                busy,
   input  wire  [cq_pkg::TYPE_W-1:0]          req_type,
   input  wire  [cq_pkg::INDEX_W-1:0]         req_index,
   input  wire  signed [cq_pkg::COORD_W-1:0]  req_coord_x,
   input  wire  signed [cq_pkg::COORD_W-1:0]  req_coord_y,
   input  wire  signed [cq_pkg::COORD_W-1:0]  req_coord_z,
   input  wire  [cq_pkg::TAG_W-1:0]           req_tag,
   input  wire  [cq_pkg::DIM_W-1:0]           req_select_dim,
   input  wire  [cq_pkg::INDEX_W-1:0]         req_range_low,
   input  wire  [cq_pkg::INDEX_W-1:0]         req_range_high,
   input  wire  [cq_pkg::INDEX_W-1:0]         req_select_rank,
   input  wire                                rsp_valid,
   input  wire  signed [cq_pkg::COORD_W-1:0]  rsp_out_x,
   input  wire  signed [cq_pkg::COORD_W-1:0]  rsp_out_y,
   input  wire  signed [cq_pkg::COORD_W-1:0]  rsp_out_z,
   input  wire  [cq_pkg::TAG_W-1:0]           rsp_out_tag,
   input  wire                                rsp_status,
   input  wire                                end_of_test,
   output int                                 fail_count,
   output int                                 outstanding,
   output int                                 checked_count
);
   import cq_pkg::*;

   // One expected result item, with the number of the item that caused it.
   typedef struct {
      rec_type     rec;
      logic        status;
      int unsigned item;
   } record_result_t;

   rec_type        record_mirror [DEPTH];
   record_result_t expected_results [$];
   int             errors = 0;
   int             compared = 0;
   int unsigned    accepted = 0;
   bit             leftovers_reported = 1'b0;
   record_result_t oldest;

   initial begin
      fail_count = 0;
      outstanding = 0;
      checked_count = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $realtime, msg);
      errors++;
   endtask

   // Coordinate of a record on the given axis.
   function automatic logic signed [COORD_W-1:0] axis_coord(rec_type r,
                                                            logic [DIM_W-1:0] d);
      return (d == DIM_Y) ? r.y : ((d == DIM_Z) ? r.z : r.x);
   endfunction

   function automatic void swap_records(int a, int b);
      rec_type t;
      t = record_mirror[a];
      record_mirror[a] = record_mirror[b];
      record_mirror[b] = t;
   endfunction

   // Hoare-style selection on the mirror, with the exact swap order of the
   // block so that equal keys end up in the same places.
   function automatic void quickselect(logic [DIM_W-1:0] d, int k, int l, int r);
      logic signed [COORD_W-1:0] pivot;
      int      i;
      int      j;
      rec_type held;
      while (r > l) begin
         pivot = axis_coord(record_mirror[k], d);
         swap_records(r, k);
         i = l - 1;
         j = r;
         forever begin
            while (i < j) begin
               i++;
               if (axis_coord(record_mirror[i], d) >= pivot) break;
            end
            while (i < j) begin
               j--;
               if (axis_coord(record_mirror[j], d) <= pivot) break;
            end
            held = record_mirror[i];
            swap_records(i, j);
            if (j <= i) break;
         end
         // Undo the last swap and put the pivot in its final place.
         record_mirror[j] = record_mirror[i];
         record_mirror[i] = record_mirror[r];
         record_mirror[r] = held;
         if (i >= k) r = i - 1;
         if (i <= k) l = i + 1;
      end
   endfunction

   // Apply one accepted item to the mirror and return its result item.
   function automatic record_result_t predict_result(
      logic [TYPE_W-1:0] kind, pos_type idx, logic signed [COORD_W-1:0] cx,
      logic signed [COORD_W-1:0] cy, logic signed [COORD_W-1:0] cz,
      logic [TAG_W-1:0] t, logic [DIM_W-1:0] d, pos_type lo, pos_type hi,
      pos_type rank);
      record_result_t res;
      res.rec = '0;
      res.status = 1'b1;
      res.item = accepted;
      case (op_type'(kind))
         OP_WRITE: begin
            if (idx < DEPTH) begin
               record_mirror[idx].x = cx;
               record_mirror[idx].y = cy;
               record_mirror[idx].z = cz;
               record_mirror[idx].tag = t;
               res.rec = record_mirror[idx];
               res.status = 1'b0;
            end
         end
         OP_SELECT: begin
            if (d <= DIM_Z && rank >= lo && rank <= hi && hi < DEPTH) begin
               quickselect(d, int'(rank), int'(lo), int'(hi));
               res.rec = record_mirror[rank];
               res.status = 1'b0;
            end
         end
         OP_READ: begin
            if (idx < DEPTH) begin
               res.rec = record_mirror[idx];
               res.status = 1'b0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Compare result items, then record newly accepted items.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result item with none expected: %h %h %h %h %b",
                                         rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_tag,
                                         rsp_status));
            end else begin
               oldest = expected_results.pop_front();
               compared++;
               if (rsp_out_x !== oldest.rec.x)
                  report_mismatch($sformatf("item %0d out_x: got %0d, expected %0d",
                                            oldest.item, rsp_out_x, oldest.rec.x));
               if (rsp_out_y !== oldest.rec.y)
                  report_mismatch($sformatf("item %0d out_y: got %0d, expected %0d",
                                            oldest.item, rsp_out_y, oldest.rec.y));
               if (rsp_out_z !== oldest.rec.z)
                  report_mismatch($sformatf("item %0d out_z: got %0d, expected %0d",
                                            oldest.item, rsp_out_z, oldest.rec.z));
               if (rsp_out_tag !== oldest.rec.tag)
                  report_mismatch($sformatf("item %0d out_tag: got %0d, expected %0d",
                                            oldest.item, rsp_out_tag, oldest.rec.tag));
               if (rsp_status !== oldest.status)
                  report_mismatch($sformatf("item %0d status: got %b, expected %b",
                                            oldest.item, rsp_status, oldest.status));
            end
         end
         if (start && !busy) begin
            expected_results.push_back(predict_result(
               req_type, req_index, req_coord_x, req_coord_y, req_coord_z, req_tag,
               req_select_dim, req_range_low, req_range_high, req_select_rank));
            accepted++;
         end
         // Anything still waiting at the end never got its result.
         if (end_of_test && !leftovers_reported) begin
            foreach (expected_results[n])
               report_mismatch($sformatf("item %0d never produced a result",
                                         expected_results[n].item));
            leftovers_reported = 1'b1;
         end
      end
      fail_count <= errors;
      outstanding <= expected_results.size();
      checked_count <= compared;
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the coordinate quickselect engine
// Drives write, select, read and unused-code items with random gaps, first a
// directed set of corner cases and then random fill, select and read-back
// rounds; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module testbench;
   import cq_pkg::*;

   localparam int unsigned      DEPTH       = 1024;
   localparam int               ITEM_TARGET = 140;
   localparam logic [DIM_W-1:0] DIM_BAD     = 2'd3;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [TYPE_W-1:0]         req_type;
   logic [INDEX_W-1:0]        req_index;
   logic signed [COORD_W-1:0] req_coord_x;
   logic signed [COORD_W-1:0] req_coord_y;
   logic signed [COORD_W-1:0] req_coord_z;
   logic [TAG_W-1:0]          req_tag;
   logic [DIM_W-1:0]          req_select_dim;
   logic [INDEX_W-1:0]        req_range_low;
   logic [INDEX_W-1:0]        req_range_high;
   logic [INDEX_W-1:0]        req_select_rank;
   logic                      rsp_valid;
   logic signed [COORD_W-1:0] rsp_out_x;
   logic signed [COORD_W-1:0] rsp_out_y;
   logic signed [COORD_W-1:0] rsp_out_z;
   logic [TAG_W-1:0]          rsp_out_tag;
   logic                      rsp_status;
   logic                      end_of_test;
   int                        fail_count;
   int                        outstanding;
   int                        checked_count;

   // Stimulus bookkeeping: which records hold data, and what was sent.
   bit written [DEPTH];
   int written_list [$];
   bit burst = 1'b0;
   int item_count = 0;
   int n_write = 0;
   int n_select = 0;
   int n_refused = 0;
   int n_read = 0;
   int n_none = 0;

   always #1 clock = ~clock;

   coordinate_quickselect #(.DEPTH(DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_index       (req_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_tag         (req_tag),
      .req_select_dim  (req_select_dim),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .req_select_rank (req_select_rank),
      .rsp_valid       (rsp_valid),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_status      (rsp_status)
   );

   quickselect_checker #(.DEPTH(DEPTH)) result_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_index       (req_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_tag         (req_tag),
      .req_select_dim  (req_select_dim),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .req_select_rank (req_select_rank),
      .rsp_valid       (rsp_valid),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_status      (rsp_status),
      .end_of_test     (end_of_test),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .checked_count   (checked_count)
   );

   function automatic rec_type make_record(logic signed [COORD_W-1:0] x,
                                           logic signed [COORD_W-1:0] y,
                                           logic signed [COORD_W-1:0] z,
                                           logic [TAG_W-1:0] t);
      rec_type r;
      r.x = x;
      r.y = y;
      r.z = z;
      r.tag = t;
      return r;
   endfunction

   function automatic rec_type random_record();
      return make_record($urandom, $urandom, $urandom, $urandom_range(0, 1023));
   endfunction

   // Coordinate source: full range, a few small values that repeat often, or the
   // extremes, zero and -1; mode 3 mixes the others per value.
   function automatic logic signed [COORD_W-1:0] pick_coord(int mode);
      int m;
      logic signed [COORD_W-1:0] v;
      m = (mode == 3) ? $urandom_range(0, 2) : mode;
      case (m)
         0: v = $urandom;
         1: v = $urandom_range(0, 6) - 3;
         default: begin
            case ($urandom_range(0, 3))
               0: v = COORD_MIN;
               1: v = COORD_MAX;
               2: v = '0;
               default: v = -1;
            endcase
         end
      endcase
      return v;
   endfunction

   // Random gap after an item: mostly none, sometimes short, rarely long; none in a burst.
   task automatic idle_gap();
      int n;
      int r;
      r = $urandom_range(0, 99);
      if (burst) n = 0;
      else if (r < 55) n = 0;
      else if (r < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Present one item and hold it until the block takes it.
   task automatic issue(input op_type op, input pos_type idx, input rec_type rec,
                        input logic [DIM_W-1:0] d, input pos_type lo,
                        input pos_type hi, input pos_type rank);
      start <= 1'b1;
      req_type <= op;
      req_index <= idx;
      req_coord_x <= rec.x;
      req_coord_y <= rec.y;
      req_coord_z <= rec.z;
      req_tag <= rec.tag;
      req_select_dim <= d;
      req_range_low <= lo;
      req_range_high <= hi;
      req_select_rank <= rank;
      do @(posedge clock); while (busy);
      item_count++;
      idle_gap();
   endtask

   task automatic put_record(input int idx, input rec_type rec);
      issue(OP_WRITE, idx, rec, $urandom_range(0, 3), $urandom_range(0, 1023),
            $urandom_range(0, 1023), $urandom_range(0, 1023));
      if (!written[idx]) begin
         written[idx] = 1'b1;
         written_list.push_back(idx);
      end
      n_write++;
   endtask

   task automatic get_record(input int idx);
      issue(OP_READ, idx, random_record(), $urandom_range(0, 3),
            $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
      n_read++;
   endtask

   task automatic select_on(input logic [DIM_W-1:0] d, input int lo, input int hi,
                            input int rank);
      if (d == DIM_BAD || rank < lo || rank > hi) n_refused++;
      else n_select++;
      issue(OP_SELECT, $urandom_range(0, 1023), random_record(), d, lo, hi, rank);
   endtask

   task automatic send_none();
      issue(OP_NONE, $urandom_range(0, 1023), random_record(), $urandom_range(0, 3),
            $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
      n_none++;
   endtask

   // Widest run of written records around p, at most 64 long.
   task automatic written_span(input int p, output int lo, output int hi);
      lo = p;
      hi = p;
      while (lo > 0 && written[lo-1] && hi - lo < 63) lo--;
      while (hi < DEPTH - 1 && written[hi+1] && hi - lo < 63) hi++;
   endtask

   task automatic read_any_written();
      get_record(written_list[$urandom_range(0, written_list.size() - 1)]);
   endtask

   // Odd items between the well-formed rounds.
   task automatic noise_item();
      logic [DIM_W-1:0] d;
      int lo;
      int hi;
      int rank;
      case ($urandom_range(0, 3))
         0: begin
            // Select that must be refused: random fields, pushed out of range.
            d = $urandom_range(0, 3);
            lo = $urandom_range(0, 1023);
            hi = $urandom_range(0, 1023);
            rank = $urandom_range(0, 1023);
            if (d != DIM_BAD && lo <= rank && rank <= hi) begin
               if (hi < DEPTH - 1) rank = hi + 1;
               else if (lo > 0) rank = lo - 1;
               else d = DIM_BAD;
            end
            select_on(d, lo, hi, rank);
         end
         1: send_none();
         2: put_record($urandom_range(0, 1023), random_record());
         default: read_any_written();
      endcase
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      int bases [3];
      int window;
      int len;
      int mode;
      int lo;
      int hi;
      int a;
      int b;
      int rank;
      bases[0] = 0;
      bases[1] = 448;
      bases[2] = 936;
      reset <= 1'b1;
      start <= 1'b0;
      end_of_test <= 1'b0;
      req_type <= OP_NONE;
      req_index <= '0;
      req_coord_x <= '0;
      req_coord_y <= '0;
      req_coord_z <= '0;
      req_tag <= '0;
      req_select_dim <= DIM_X;
      req_range_low <= '0;
      req_range_high <= '0;
      req_select_rank <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, equal keys on y, and every refusal reason.
      put_record(0, make_record(COORD_MIN, 3, 7, 0));
      put_record(1, make_record(COORD_MAX, 3, -2, 1023));
      put_record(2, make_record(5, 3, COORD_MIN, 2));
      put_record(3, make_record(5, 3, COORD_MAX, 3));
      put_record(4, make_record(-1, 3, 0, 4));
      put_record(5, make_record(0, 3, 7, 5));
      put_record(6, make_record(5, 3, 7, 6));
      put_record(7, make_record(-7, 3, -2, 7));
      select_on(DIM_X, 0, 7, 3);
      select_on(DIM_Y, 0, 7, 0);
      select_on(DIM_Z, 0, 7, 7);
      select_on(DIM_X, 5, 5, 5);
      select_on(DIM_Z, 2, 3, 2);
      select_on(DIM_X, 4, 7, 3);
      select_on(DIM_X, 0, 6, 7);
      select_on(DIM_Y, 6, 2, 4);
      select_on(DIM_BAD, 0, 7, 3);
      send_none();
      put_record(1023, make_record(COORD_MAX, COORD_MIN, -1, 1023));
      put_record(1022, make_record(COORD_MIN, COORD_MAX, 0, 512));
      select_on(DIM_X, 1022, 1023, 1023);
      get_record(1023);
      get_record(0);
      get_record(4);

      // Random rounds: fill a run, select inside it, read back, add noise.
      while (item_count < ITEM_TARGET) begin
         burst = ($urandom_range(0, 3) == 0);
         window = bases[$urandom_range(0, 2)] + $urandom_range(0, 63);
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 32) : $urandom_range(2, 10);
         if (window + len > DEPTH) len = DEPTH - window;
         mode = $urandom_range(0, 3);
         for (int p = window; p < window + len; p++)
            put_record(p, make_record(pick_coord(mode), pick_coord(mode), pick_coord(mode),
                                      $urandom_range(0, 1023)));
         repeat ($urandom_range(2, 5)) begin
            written_span(window + $urandom_range(0, len - 1), lo, hi);
            a = $urandom_range(lo, hi);
            b = $urandom_range(lo, hi);
            if (a > b) begin
               rank = a;
               a = b;
               b = rank;
            end
            rank = $urandom_range(a, b);
            select_on($urandom_range(0, 2), a, b, rank);
            if ($urandom_range(0, 2) == 0) get_record(rank);
            if ($urandom_range(0, 3) == 0) noise_item();
         end
         repeat ($urandom_range(1, 2)) read_any_written();
         noise_item();
      end
      start <= 1'b0;

      // Drain: let the checker see the last acceptance, then wait for results.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      end_of_test <= 1'b1;
      repeat (3) @(posedge clock);

      $display("Sent %0d items: %0d writes, %0d selects, %0d refused selects, %0d reads, %0d unused codes.",
               item_count, n_write, n_select, n_refused, n_read, n_none);
      $display("Compared %0d result items with the mirrored store; %0d failures.",
               checked_count, fail_count);
      if (fail_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #8_000_000;
      $display("Timeout: the run did not finish in time.");
      $display("testbench NOT OK");
      $finish;
   end

endmodule
